@@ design/iafp_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU angle frame parser package
// Frame layout codes, raw sample bundle and fixed-point conversion constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iafp_pkg;

  // Frame layout
  localparam logic [7:0] START_BYTE = 8'h55;
  localparam logic [7:0] ANGLE_TYPE = 8'h53;

  // Frame position codes: index of the next byte of the frame
  localparam logic [3:0] POS_HUNT  = 4'd0;
  localparam logic [3:0] POS_TYPE  = 4'd1;
  localparam logic [3:0] POS_DATA0 = 4'd2;
  localparam logic [3:0] POS_CHECK = 4'd10;

  // Angle: raw * 18000 / 2^15, floored
  localparam logic signed [15:0] ANGLE_SCALE = 16'sd18000;
  localparam int                 ANGLE_SHIFT = 15;

  // Temperature: floor(raw * 5 / 17) + 3653.
  // Bias the product by 17 * 9638 so the quotient is taken on a
  // non-negative value, then divide by reciprocal multiply (exact below 2^19).
  localparam logic signed [19:0] TEMP_BIAS   = 20'sd163846;
  localparam logic [19:0]        TEMP_RECIP  = 20'd986896;
  localparam int                 TEMP_SHIFT  = 24;
  localparam logic [15:0]        TEMP_OFFSET = 16'd5985;  // 9638 - 3653

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] temp;
  } raw_frame_t;

  typedef struct packed {
    logic done;     // current byte completes a good angle frame
    logic hunting;  // parser waits for a start byte
  } parse_status_t;

endpackage

@@ design/iafp_frame_parser.sv @@
// ----------------------------------------------------------------------------
// IMU angle frame parser - frame tracker
// Hunts for the start byte, collects type, data and checksum, flags good
// angle frames and presents the assembled raw samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iafp_frame_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   enable,
  input  logic                   byte_valid,
  input  logic                   byte_take,
  input  logic [7:0]             rx_byte,
  output iafp_pkg::parse_status_t status,
  output iafp_pkg::raw_frame_t    raw
);

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] frame_type;
  logic [7:0] payload [8];
  logic [2:0] data_idx;
  logic       hunting;

  assign hunting  = (pos == iafp_pkg::POS_HUNT) || (pos > iafp_pkg::POS_CHECK);
  assign data_idx = 3'(pos - iafp_pkg::POS_DATA0);

  always_comb begin
    pos_next         = pos;
    running_sum_next = running_sum;
    if (enable) begin
      if (hunting) begin
        if (rx_byte == iafp_pkg::START_BYTE) begin
          pos_next         = iafp_pkg::POS_TYPE;
          running_sum_next = iafp_pkg::START_BYTE;
        end else begin
          pos_next = iafp_pkg::POS_HUNT;
        end
      end else if (pos == iafp_pkg::POS_CHECK) begin
        pos_next = iafp_pkg::POS_HUNT;
      end else begin
        pos_next         = pos + 4'd1;
        running_sum_next = running_sum + rx_byte;
      end
    end
  end

  assign status.done = byte_valid && enable && (pos == iafp_pkg::POS_CHECK) &&
                       (running_sum == rx_byte) &&
                       (frame_type == iafp_pkg::ANGLE_TYPE);
  assign status.hunting = hunting;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= iafp_pkg::POS_HUNT;
      running_sum <= '0;
    end else if (byte_take) begin
      pos         <= pos_next;
      running_sum <= running_sum_next;
    end
  end

  // type and data bytes carry no reset
  always_ff @(posedge clk) begin
    if (byte_take && enable && !hunting) begin
      if (pos == iafp_pkg::POS_TYPE) begin
        frame_type <= rx_byte;
      end else if (pos != iafp_pkg::POS_CHECK) begin
        payload[data_idx] <= rx_byte;
      end
    end
  end

  // data order: XL XH YL YH ZL ZH TL TH
  assign raw.roll  = {payload[1], payload[0]};
  assign raw.pitch = {payload[3], payload[2]};
  assign raw.yaw   = {payload[5], payload[4]};
  assign raw.temp  = {payload[7], payload[6]};

endmodule

@@ design/iafp_convert.sv @@
// ----------------------------------------------------------------------------
// IMU angle frame parser - unit conversion
// Scales raw angles to centidegrees and raw temperature to centidegrees C,
// all with floor rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iafp_convert (
  input  iafp_pkg::raw_frame_t raw,
  output logic signed [15:0]   roll_centideg,
  output logic signed [15:0]   pitch_centideg,
  output logic signed [15:0]   yaw_centideg,
  output logic signed [14:0]   temp_centideg
);

  logic signed [30:0] roll_prod;
  logic signed [30:0] pitch_prod;
  logic signed [30:0] yaw_prod;
  logic signed [19:0] temp_x5;
  logic signed [19:0] temp_biased;
  logic [18:0]        temp_u;
  logic [38:0]        temp_prod;
  logic [14:0]        temp_quot;
  logic [15:0]        temp_diff;

  assign roll_prod  = 31'(raw.roll)  * 31'(iafp_pkg::ANGLE_SCALE);
  assign pitch_prod = 31'(raw.pitch) * 31'(iafp_pkg::ANGLE_SCALE);
  assign yaw_prod   = 31'(raw.yaw)   * 31'(iafp_pkg::ANGLE_SCALE);

  // upper bits of the product are the floored quotient
  assign roll_centideg  = roll_prod[30:iafp_pkg::ANGLE_SHIFT];
  assign pitch_centideg = pitch_prod[30:iafp_pkg::ANGLE_SHIFT];
  assign yaw_centideg   = yaw_prod[30:iafp_pkg::ANGLE_SHIFT];

  // times five as shift and add, then shift into the non-negative range
  assign temp_x5     = (20'(raw.temp) <<< 2) + 20'(raw.temp);
  assign temp_biased = temp_x5 + iafp_pkg::TEMP_BIAS;
  assign temp_u      = temp_biased[18:0];
  assign temp_prod   = 39'(temp_u) * 39'(iafp_pkg::TEMP_RECIP);
  assign temp_quot   = temp_prod[38:iafp_pkg::TEMP_SHIFT];
  assign temp_diff   = {1'b0, temp_quot} - iafp_pkg::TEMP_OFFSET;
  assign temp_centideg = temp_diff[14:0];

endmodule

@@ design/imu_angle_frame_parser.sv @@
// ----------------------------------------------------------------------------
// IMU angle frame parser
// Parses 11-byte sensor frames from a byte stream and emits roll, pitch,
// yaw and temperature for every angle frame with a good checksum.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// config    in         cfg_wen                cfg_wdata (enable)
// bytes     in         in_valid / in_stall    rx_byte
// angles    out        out_valid / out_stall  roll, pitch, yaw, temp centideg
//
// One byte is taken every cycle unless in_stall is raised. A byte is held in
// the input register while the frame tracker works on it, the tracker closes
// a good frame into the sample register, and the conversion fills the output
// register from the sample register once the output is free.
// Reset clears the enable, the frame position, the checksum and all valids.
// A stall on the output backs up through the sample register; bytes that
// do not close a frame keep flowing while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_angle_frame_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_centideg,
  output logic signed [15:0] pitch_centideg,
  output logic signed [15:0] yaw_centideg,
  output logic signed [14:0] temp_centideg
);

  logic                    enable;
  logic                    s0_valid;
  logic [7:0]              s0_byte;
  logic                    s0_take;
  logic                    s1_valid;
  logic                    s1_ready;
  logic                    s2_ready;
  iafp_pkg::raw_frame_t    s1_raw;
  iafp_pkg::raw_frame_t    parse_raw;
  iafp_pkg::parse_status_t status;
  logic signed [15:0]      roll_conv;
  logic signed [15:0]      pitch_conv;
  logic signed [15:0]      yaw_conv;
  logic signed [14:0]      temp_conv;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_wen) begin
      enable <= cfg_wdata;
    end
  end

  assign s2_ready = !out_valid || !out_stall;
  assign s1_ready = !s1_valid || s2_ready;
  // a byte that closes no frame never waits on the sample register
  assign s0_take  = s0_valid && (s1_ready || !status.done);
  assign in_stall = s0_valid && !s0_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s0_valid <= 1'b1;
    end else if (s0_take) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_byte <= rx_byte;
    end
  end

  iafp_frame_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .enable     (enable),
    .byte_valid (s0_valid),
    .byte_take  (s0_take),
    .rx_byte    (s0_byte),
    .status     (status),
    .raw        (parse_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s0_take && status.done) begin
      s1_valid <= 1'b1;
    end else if (s2_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_take && status.done) begin
      s1_raw <= parse_raw;
    end
  end

  iafp_convert u_convert (
    .raw            (s1_raw),
    .roll_centideg  (roll_conv),
    .pitch_centideg (pitch_conv),
    .yaw_centideg   (yaw_conv),
    .temp_centideg  (temp_conv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s2_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      roll_centideg  <= roll_conv;
      pitch_centideg <= pitch_conv;
      yaw_centideg   <= yaw_conv;
      temp_centideg  <= temp_conv;
    end
  end

  // a closed frame always sends the tracker back to hunting
  assert property (@(posedge clk) disable iff (rst)
    (s0_take && status.done) |=> status.hunting)
    else $error("parser did not return to hunting after a good frame");

  // a result only appears after a sample was held
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without a captured frame");

  // temperature stays at or above the floor of the conversion
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temp_centideg >= -15'sd5985))
    else $error("temperature out of range");

  // a disabled parser never closes a frame
  assert property (@(posedge clk) disable iff (rst)
    !enable |-> !status.done)
    else $error("frame closed while disabled");

endmodule
